// ===== hw/rtl/pgt_pkg.sv =====
// Shared operation and status codes for the process group tracker.
package pgt_pkg;

   localparam logic [1:0] FUNC_NEW  = 2'd0;
   localparam logic [1:0] FUNC_FORK = 2'd1;
   localparam logic [1:0] FUNC_EXIT = 2'd2;
   localparam logic [1:0] FUNC_READ = 2'd3;

   localparam logic [1:0] STATUS_OK         = 2'd0;
   localparam logic [1:0] STATUS_TABLE_FULL = 2'd1;
   localparam logic [1:0] STATUS_GROUP_FULL = 2'd2;
   localparam logic [1:0] STATUS_BAD_INDEX  = 2'd3;

   typedef logic [1:0] func_type;
   typedef logic [1:0] status_type;

endpackage

// ===== hw/rtl/pgt_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
module pgt_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                       clock,
   input  logic                       wr_en,
   input  logic [$clog2(DEPTH)-1:0]   wr_addr,
   input  logic [WIDTH-1:0]           wr_data,
   input  logic [$clog2(DEPTH)-1:0]   rd_addr,
   output logic [WIDTH-1:0]           rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== hw/rtl/process_group_tracker.sv =====
// Process group tracker: group table sequencer over member and size memories.
// New group and read member finish without a scan. Fork and exit walk every group in use
// and scan its members; exit also shrinks each group that holds the id, and a group that
// it empties is deleted, and the last group is copied into its slot.
// One transaction is processed at a time; the member memory scan sets the rate.
// Reset clears the group count and control; the memories are not cleared.
module process_group_tracker #(
   parameter int MAX_GROUPS  = 128,
   parameter int MAX_MEMBERS = 1024,
   parameter int ID_BITS     = 22
) (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   // req_tdata, from bit 0: pid, parent, group_sel, slot_sel, zero fill.
   input  logic [((2*ID_BITS+$clog2(MAX_GROUPS)+$clog2(MAX_MEMBERS)+7)/8)*8-1:0] req_tdata,
   // req_tuser: func.
   input  pgt_pkg::func_type req_tuser,
   output logic rsp_tvalid,
   input  logic rsp_tready,
   // rsp_tdata, from bit 0: status, groups_in_use, groups_changed,
   // new_group_index, member_pid, member_count, zero fill.
   output logic [((4+2*$clog2(MAX_GROUPS+1)+$clog2(MAX_GROUPS)+ID_BITS
                   +$clog2(MAX_MEMBERS+1)+7)/8)*8-1:0] rsp_tdata
);
   import pgt_pkg::*;

   localparam int GW  = $clog2(MAX_GROUPS);
   localparam int GCW = $clog2(MAX_GROUPS + 1);
   localparam int MW  = $clog2(MAX_MEMBERS);
   localparam int MCW = $clog2(MAX_MEMBERS + 1);
   localparam int AW  = GW + MW;
   localparam int RSP_BITS = 2 + 2*GCW + GW + ID_BITS + MCW;
   localparam int RSP_W = ((RSP_BITS + 2 + 7) / 8) * 8;
   localparam int PID_LO = 0;
   localparam int PAR_LO = ID_BITS;
   localparam int GS_LO  = 2 * ID_BITS;
   localparam int SS_LO  = 2 * ID_BITS + GW;

   localparam logic [3:0] ST_IDLE    = 4'd0;
   localparam logic [3:0] ST_RD_SIZE = 4'd1;
   localparam logic [3:0] ST_RD_MEM  = 4'd2;
   localparam logic [3:0] ST_G_START = 4'd3;
   localparam logic [3:0] ST_G_SIZE  = 4'd4;
   localparam logic [3:0] ST_SCAN    = 4'd5;
   localparam logic [3:0] ST_DECIDE  = 4'd6;
   localparam logic [3:0] ST_EX_MOVE = 4'd7;
   localparam logic [3:0] ST_MV_SIZE = 4'd8;
   localparam logic [3:0] ST_COPY    = 4'd9;
   localparam logic [3:0] ST_DONE    = 4'd10;

   // Input transaction fields.
   logic [ID_BITS-1:0] req_pid, req_parent;
   logic [GW-1:0]      req_gsel;
   logic [MW-1:0]      req_ssel;
   assign req_pid    = req_tdata[PID_LO +: ID_BITS];
   assign req_parent = req_tdata[PAR_LO +: ID_BITS];
   assign req_gsel   = req_tdata[GS_LO +: GW];
   assign req_ssel   = req_tdata[SS_LO +: MW];

   // Control and working registers.
   logic [3:0]         state_ff, state_in;
   func_type           func_ff, func_in;
   logic [ID_BITS-1:0] pid_ff, pid_in, par_ff, par_in;
   logic [GW-1:0]      gsel_ff, gsel_in;
   logic [MW-1:0]      ssel_ff, ssel_in;
   status_type         status_ff, status_in;
   logic [GCW-1:0]     changed_ff, changed_in;
   logic [GW-1:0]      new_idx_ff, new_idx_in;
   logic [ID_BITS-1:0] rdpid_ff, rdpid_in;
   logic [MCW-1:0]     rdcnt_ff, rdcnt_in;
   logic [GCW-1:0]     total_ff, total_in;
   logic [GCW-1:0]     g_ff, g_in;
   logic [MCW-1:0]     m_ff, m_in;
   logic [MCW-1:0]     size_ff, size_in;
   logic               fp_ff, fp_in, fc_ff, fc_in;
   logic [MW-1:0]      pos_ff, pos_in;
   logic               scan_vld_ff, scan_vld_in;
   logic [MW-1:0]      scan_idx_ff, scan_idx_in;
   logic [GW-1:0]      src_ff, src_in;
   logic               rsp_valid_ff, rsp_valid_in;
   logic [RSP_W-1:0]   rsp_data_ff, rsp_data_in;

   // Memory ports.
   logic               mem_we;
   logic [AW-1:0]      mem_waddr, mem_raddr;
   logic [ID_BITS-1:0] mem_wdata, mem_rdata;
   logic               sz_we;
   logic [GW-1:0]      sz_waddr, sz_raddr;
   logic [MCW-1:0]     sz_wdata, sz_rdata;

   pgt_ram #(.WIDTH(ID_BITS), .DEPTH(MAX_GROUPS * (2 ** MW))) u_member_ram (
      .clock   (clock),
      .wr_en   (mem_we),
      .wr_addr (mem_waddr),
      .wr_data (mem_wdata),
      .rd_addr (mem_raddr),
      .rd_data (mem_rdata)
   );

   pgt_ram #(.WIDTH(MCW), .DEPTH(MAX_GROUPS)) u_size_ram (
      .clock   (clock),
      .wr_en   (sz_we),
      .wr_addr (sz_waddr),
      .wr_data (sz_wdata),
      .rd_addr (sz_raddr),
      .rd_data (sz_rdata)
   );

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // Sequencer. Fork and exit walk the groups in order; each group's size is
   // read first and then its members stream out of the member memory one per
   // cycle, compared in the next cycle against the parent and the id.
   always_comb begin
      logic [MCW-1:0] last;
      logic [GCW-1:0] tot_dec;
      last    = size_ff - MCW'(1);
      tot_dec = total_ff - GCW'(1);

      state_in    = state_ff;
      func_in     = func_ff;
      pid_in      = pid_ff;
      par_in      = par_ff;
      gsel_in     = gsel_ff;
      ssel_in     = ssel_ff;
      status_in   = status_ff;
      changed_in  = changed_ff;
      new_idx_in  = new_idx_ff;
      rdpid_in    = rdpid_ff;
      rdcnt_in    = rdcnt_ff;
      total_in    = total_ff;
      g_in        = g_ff;
      m_in        = m_ff;
      size_in     = size_ff;
      fp_in       = fp_ff;
      fc_in       = fc_ff;
      pos_in      = pos_ff;
      scan_vld_in = scan_vld_ff;
      scan_idx_in = scan_idx_ff;
      src_in      = src_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_tready;
      rsp_data_in  = rsp_data_ff;

      mem_we    = 1'b0;
      mem_waddr = '0;
      mem_wdata = '0;
      mem_raddr = '0;
      sz_we     = 1'b0;
      sz_waddr  = '0;
      sz_wdata  = '0;
      sz_raddr  = '0;

      unique case (state_ff)
         ST_IDLE: begin
            if (req_tvalid) begin
               func_in    = req_tuser;
               pid_in     = req_pid;
               par_in     = req_parent;
               gsel_in    = req_gsel;
               ssel_in    = req_ssel;
               status_in  = STATUS_OK;
               changed_in = '0;
               new_idx_in = '0;
               rdpid_in   = '0;
               rdcnt_in   = '0;
               g_in       = '0;
               unique case (req_tuser)
                  FUNC_NEW: begin
                     if (total_ff == GCW'(MAX_GROUPS)) begin
                        status_in = STATUS_TABLE_FULL;
                     end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = {total_ff[GW-1:0], {MW{1'b0}}};
                        mem_wdata  = req_pid;
                        sz_we      = 1'b1;
                        sz_waddr   = total_ff[GW-1:0];
                        sz_wdata   = MCW'(1);
                        total_in   = total_ff + GCW'(1);
                        new_idx_in = total_ff[GW-1:0];
                        changed_in = GCW'(1);
                     end
                     state_in = ST_DONE;
                  end
                  FUNC_FORK, FUNC_EXIT: begin
                     state_in = ST_G_START;
                  end
                  FUNC_READ: begin
                     if (GCW'(req_gsel) >= total_ff) begin
                        status_in = STATUS_BAD_INDEX;
                        state_in  = ST_DONE;
                     end else begin
                        sz_raddr = req_gsel;
                        state_in = ST_RD_SIZE;
                     end
                  end
                  default: state_in = ST_DONE;
               endcase
            end
         end
         ST_RD_SIZE: begin
            rdcnt_in = sz_rdata;
            if (MCW'(ssel_ff) >= sz_rdata) begin
               status_in = STATUS_BAD_INDEX;
               state_in  = ST_DONE;
            end else begin
               mem_raddr = {gsel_ff, ssel_ff};
               state_in  = ST_RD_MEM;
            end
         end
         ST_RD_MEM: begin
            rdpid_in = mem_rdata;
            state_in = ST_DONE;
         end
         ST_G_START: begin
            if (g_ff >= total_ff) begin
               state_in = ST_DONE;
            end else begin
               sz_raddr = g_ff[GW-1:0];
               state_in = ST_G_SIZE;
            end
         end
         ST_G_SIZE: begin
            size_in     = sz_rdata;
            m_in        = '0;
            fp_in       = 1'b0;
            fc_in       = 1'b0;
            scan_vld_in = 1'b0;
            state_in    = ST_SCAN;
         end
         ST_SCAN: begin
            if (scan_vld_ff) begin
               if (mem_rdata == par_ff) begin
                  fp_in = 1'b1;
               end
               if (mem_rdata == pid_ff) begin
                  fc_in  = 1'b1;
                  pos_in = scan_idx_ff;
               end
            end
            if (m_ff < size_ff) begin
               mem_raddr   = {g_ff[GW-1:0], m_ff[MW-1:0]};
               scan_idx_in = m_ff[MW-1:0];
               scan_vld_in = 1'b1;
               m_in        = m_ff + MCW'(1);
            end else begin
               scan_vld_in = 1'b0;
               if (!scan_vld_ff) begin
                  state_in = ST_DECIDE;
               end
            end
         end
         ST_DECIDE: begin
            if (func_ff == FUNC_FORK) begin
               if (fp_ff && !fc_ff) begin
                  if (size_ff == MCW'(MAX_MEMBERS)) begin
                     status_in = STATUS_GROUP_FULL;
                  end else begin
                     mem_we     = 1'b1;
                     mem_waddr  = {g_ff[GW-1:0], size_ff[MW-1:0]};
                     mem_wdata  = pid_ff;
                     sz_we      = 1'b1;
                     sz_waddr   = g_ff[GW-1:0];
                     sz_wdata   = size_ff + MCW'(1);
                     changed_in = changed_ff + GCW'(1);
                  end
               end
               g_in     = g_ff + GCW'(1);
               state_in = ST_G_START;
            end else if (!fc_ff) begin
               g_in     = g_ff + GCW'(1);
               state_in = ST_G_START;
            end else begin
               changed_in = changed_ff + GCW'(1);
               mem_raddr  = {g_ff[GW-1:0], last[MW-1:0]};
               state_in   = ST_EX_MOVE;
            end
         end
         ST_EX_MOVE: begin
            // The last member fills the gap left by the removed id.
            mem_we    = 1'b1;
            mem_waddr = {g_ff[GW-1:0], pos_ff};
            mem_wdata = mem_rdata;
            sz_we     = 1'b1;
            sz_waddr  = g_ff[GW-1:0];
            sz_wdata  = last;
            if (last == '0) begin
               total_in = tot_dec;
               if (g_ff != tot_dec) begin
                  src_in   = tot_dec[GW-1:0];
                  sz_raddr = tot_dec[GW-1:0];
                  state_in = ST_MV_SIZE;
               end else begin
                  state_in = ST_G_START;
               end
            end else begin
               g_in     = g_ff + GCW'(1);
               state_in = ST_G_START;
            end
         end
         ST_MV_SIZE: begin
            size_in     = sz_rdata;
            sz_we       = 1'b1;
            sz_waddr    = g_ff[GW-1:0];
            sz_wdata    = sz_rdata;
            m_in        = '0;
            scan_vld_in = 1'b0;
            state_in    = ST_COPY;
         end
         ST_COPY: begin
            // The last group moves into the emptied slot, which is then rescanned.
            if (scan_vld_ff) begin
               mem_we    = 1'b1;
               mem_waddr = {g_ff[GW-1:0], scan_idx_ff};
               mem_wdata = mem_rdata;
            end
            if (m_ff < size_ff) begin
               mem_raddr   = {src_ff, m_ff[MW-1:0]};
               scan_idx_in = m_ff[MW-1:0];
               scan_vld_in = 1'b1;
               m_in        = m_ff + MCW'(1);
            end else begin
               scan_vld_in = 1'b0;
               if (!scan_vld_ff) begin
                  state_in = ST_G_START;
               end
            end
         end
         ST_DONE: begin
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_valid_in = 1'b1;
               rsp_data_in  = RSP_W'({rdcnt_ff, rdpid_ff, new_idx_ff, changed_ff,
                                      total_ff, status_ff});
               state_in     = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         total_ff     <= '0;
         scan_vld_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         total_ff     <= total_in;
         scan_vld_ff  <= scan_vld_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      func_ff     <= func_in;
      pid_ff      <= pid_in;
      par_ff      <= par_in;
      gsel_ff     <= gsel_in;
      ssel_ff     <= ssel_in;
      status_ff   <= status_in;
      changed_ff  <= changed_in;
      new_idx_ff  <= new_idx_in;
      rdpid_ff    <= rdpid_in;
      rdcnt_ff    <= rdcnt_in;
      g_ff        <= g_in;
      m_ff        <= m_in;
      size_ff     <= size_in;
      fp_ff       <= fp_in;
      fc_ff       <= fc_in;
      pos_ff      <= pos_in;
      scan_idx_ff <= scan_idx_in;
      src_ff      <= src_in;
      rsp_data_ff <= rsp_data_in;
   end

`ifndef SYNTH
   // The group count never passes the table size.
   assert property (@(posedge clock) disable iff (reset)
      total_ff <= GCW'(MAX_GROUPS))
      else $error("group count above table size");

   // A member scan only reads; nothing may write the member memory meanwhile.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_SCAN) |-> !mem_we)
      else $error("member write during scan");

   // A group copy never writes into the group it reads from.
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_COPY && mem_we) |-> (g_ff[GW-1:0] != src_ff))
      else $error("group copy onto itself");

   // A successful new group raises the group count by one.
   assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready && req_tuser == FUNC_NEW
       && total_ff < GCW'(MAX_GROUPS))
      |=> (total_ff == $past(total_ff) + GCW'(1)))
      else $error("new group did not raise the group count");
`endif

endmodule
